// ===== rtl/core/ppc_pkg.sv =====
// ppc_pkg: shared types and constants for the purifier panel controller
// no dependencies; imported by purifier_panel_controller
package ppc_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int CHASE_STEPS_DEF = 4;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int PERIOD_W    = 8;
  localparam int FAN_W       = 2;
  localparam int NIBBLE_W    = 4;

  // configuration register reset values
  localparam logic [CFG_DATA_W-1:0] SMART_LOW_RST  = 32'd300000;
  localparam logic [CFG_DATA_W-1:0] SMART_HIGH_RST = 32'd600000;
  localparam logic [CFG_DATA_W-1:0] WAKE_IDLE_RST  = 32'd5000;
  localparam logic [PERIOD_W-1:0]   PERIOD_LOW_RST  = 8'd200;
  localparam logic [PERIOD_W-1:0]   PERIOD_MID_RST  = 8'd100;
  localparam logic [PERIOD_W-1:0]   PERIOD_HIGH_RST = 8'd50;

  localparam logic [NIBBLE_W-1:0] WHEEL_DARK    = 4'hF;
  localparam logic [NIBBLE_W-1:0] WHEEL_LIT     = 4'h0;
  localparam logic [NIBBLE_W-1:0] PATTERN_FIRST = 4'h1;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_KEY  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    KEY_POWER   = 3'd0,
    KEY_SMART   = 3'd1,
    KEY_PURIFY  = 3'd2,
    KEY_LIGHT   = 3'd3,
    KEY_MOVE    = 3'd4,
    KEY_RESERVE = 3'd5,
    KEY_TIMER   = 3'd6,
    KEY_UNUSED  = 3'd7
  } key_t;

  typedef enum logic [FAN_W-1:0] {
    FAN_OFF  = 2'd0,
    FAN_LOW  = 2'd1,
    FAN_MID  = 2'd2,
    FAN_HIGH = 2'd3
  } fan_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SMART_LOW   = 3'd0,
    REG_SMART_HIGH  = 3'd1,
    REG_WAKE_IDLE   = 3'd2,
    REG_PERIOD_LOW  = 3'd3,
    REG_PERIOD_MID  = 3'd4,
    REG_PERIOD_HIGH = 3'd5
  } reg_index_t;

  // indicator group bits
  typedef struct packed {
    logic timer;
    logic smart;
    logic purifier;
    logic light;
    logic panel;
  } indicators_t;

endpackage

// ===== rtl/core/purifier_panel_controller.sv =====
// purifier_panel_controller: front-panel mode, timer and LED control
// depends on ppc_pkg
// latency: a result is valid the cycle after its item transfer
// throughput: one item per cycle while the result is not stalled; the mode state updates in a single registered pass
// the mode registers double as the result register, held while the result is stalled
// reset (synchronous): unit off, wheel dark, counters cleared, registers at defaults
module purifier_panel_controller #(
  parameter int COUNT_WIDTH = ppc_pkg::COUNT_WIDTH_DEF,
  parameter int CHASE_STEPS = ppc_pkg::CHASE_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // item channel
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                operation,
  input  logic [2:0]                          key_code,
  input  logic                                motion,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [ppc_pkg::FAN_W-1:0]           fan_speed,
  output logic                                power_state,
  output logic                                light_drive,
  output logic                                purifier_drive,
  output logic [ppc_pkg::NIBBLE_W-1:0]        wheel_leds,
  output logic                                panel_leds,
  output logic                                light_led,
  output logic                                purifier_led,
  output logic                                smart_led,
  output logic                                timer_led,
  output logic                                beep,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ppc_pkg::*;

  localparam int CMP_W  = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;
  localparam int STEP_W = (CHASE_STEPS > 2) ? $clog2(CHASE_STEPS) : 1;

  // configuration registers
  logic [CFG_DATA_W-1:0] smart_low_ticks, smart_high_ticks, wake_idle_ticks;
  logic [PERIOD_W-1:0]   chase_period_low, chase_period_mid, chase_period_high;

  // mode state
  logic                   power_on, power_on_next;
  fan_t                   fan_mode, fan_mode_next;
  logic                   smart_mode, smart_mode_next;
  logic                   timer_mode, timer_mode_next;
  logic                   wake_enable, wake_enable_next;
  logic                   light_port, light_port_next;
  logic                   purifier_port, purifier_port_next;
  logic [COUNT_WIDTH-1:0] idle_count, idle_count_next;
  logic [COUNT_WIDTH-1:0] wake_count, wake_count_next;
  logic [PERIOD_W-1:0]    chase_delay, chase_delay_next;
  logic [STEP_W-1:0]      chase_step, chase_step_next;
  logic [NIBBLE_W-1:0]    chase_pattern, chase_pattern_next;
  logic [NIBBLE_W-1:0]    wheel_nibble, wheel_nibble_next;
  indicators_t            indicator_bits, indicator_bits_next;
  logic                   beep_next;

  logic                   accept;
  logic [PERIOD_W-1:0]    period;
  logic [STEP_W:0]        step_inc;
  logic                   idle_ge_high, idle_ge_low, wake_ge_idle;

  assign cfg_ready  = 1'b1;
  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      smart_low_ticks   <= SMART_LOW_RST;
      smart_high_ticks  <= SMART_HIGH_RST;
      wake_idle_ticks   <= WAKE_IDLE_RST;
      chase_period_low  <= PERIOD_LOW_RST;
      chase_period_mid  <= PERIOD_MID_RST;
      chase_period_high <= PERIOD_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SMART_LOW:   smart_low_ticks   <= cfg_data;
        REG_SMART_HIGH:  smart_high_ticks  <= cfg_data;
        REG_WAKE_IDLE:   wake_idle_ticks   <= cfg_data;
        REG_PERIOD_LOW:  chase_period_low  <= cfg_data[PERIOD_W-1:0];
        REG_PERIOD_MID:  chase_period_mid  <= cfg_data[PERIOD_W-1:0];
        REG_PERIOD_HIGH: chase_period_high <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // threshold compares use the counters as they stand before the tick
  assign idle_ge_high = CMP_W'(idle_count) >= CMP_W'(smart_high_ticks);
  assign idle_ge_low  = CMP_W'(idle_count) >= CMP_W'(smart_low_ticks);
  assign wake_ge_idle = CMP_W'(wake_count) >= CMP_W'(wake_idle_ticks);

  always_comb begin
    power_on_next       = power_on;
    fan_mode_next       = fan_mode;
    smart_mode_next     = smart_mode;
    timer_mode_next     = timer_mode;
    wake_enable_next    = wake_enable;
    light_port_next     = light_port;
    purifier_port_next  = purifier_port;
    idle_count_next     = idle_count;
    wake_count_next     = wake_count;
    chase_delay_next    = chase_delay;
    chase_step_next     = chase_step;
    chase_pattern_next  = chase_pattern;
    wheel_nibble_next   = wheel_nibble;
    indicator_bits_next = indicator_bits;
    beep_next           = 1'b0;
    period              = chase_period_high;
    step_inc            = '0;

    if (operation == OP_KEY) begin
      unique case (key_t'(key_code))
        KEY_POWER: begin
          beep_next = 1'b1;
          if (power_on) begin
            power_on_next                = 1'b0;
            fan_mode_next                = FAN_OFF;
            smart_mode_next              = 1'b0;
            timer_mode_next              = 1'b0;
            wake_enable_next             = 1'b1;
            wheel_nibble_next            = WHEEL_DARK;
            purifier_port_next           = 1'b0;
            light_port_next              = 1'b0;
            indicator_bits_next.panel    = 1'b0;
            indicator_bits_next.light    = 1'b0;
            indicator_bits_next.purifier = 1'b0;
          end else begin
            wake_enable_next             = 1'b0;
            timer_mode_next              = 1'b0;
            power_on_next                = 1'b1;
            fan_mode_next                = FAN_MID;
            wheel_nibble_next            = WHEEL_LIT;
            purifier_port_next           = 1'b1;
            light_port_next              = 1'b1;
            indicator_bits_next.panel    = 1'b1;
            indicator_bits_next.light    = 1'b1;
            indicator_bits_next.purifier = 1'b1;
          end
        end
        KEY_SMART: begin
          if (power_on) begin
            beep_next                 = 1'b1;
            smart_mode_next           = ~smart_mode;
            indicator_bits_next.smart = ~indicator_bits.smart;
          end
        end
        KEY_PURIFY: begin
          if (power_on) begin
            beep_next                    = 1'b1;
            purifier_port_next           = ~purifier_port;
            indicator_bits_next.purifier = ~purifier_port;
          end
        end
        KEY_LIGHT: begin
          if (power_on) begin
            beep_next                 = 1'b1;
            light_port_next           = ~light_port;
            indicator_bits_next.light = ~light_port;
          end
        end
        KEY_TIMER: begin
          if (power_on) begin
            beep_next                 = 1'b1;
            timer_mode_next           = ~timer_mode;
            indicator_bits_next.timer = ~indicator_bits.timer;
          end
        end
        default: ;
      endcase
    end else begin
      // smart auto-off, slowdown and motion boost
      if (power_on) begin
        if (smart_mode) begin
          if (idle_ge_high) begin
            idle_count_next = '0;
            power_on_next   = 1'b0;
          end else if (idle_ge_low) begin
            if (motion) begin
              fan_mode_next   = FAN_HIGH;
              idle_count_next = '0;
            end else begin
              idle_count_next = idle_count + COUNT_WIDTH'(1);
              fan_mode_next   = FAN_LOW;
            end
          end else begin
            idle_count_next = idle_count + COUNT_WIDTH'(1);
          end
        end else begin
          idle_count_next = '0;
        end
      end

      // motion wake, possible right after a smart auto-off
      if (!power_on_next && wake_enable) begin
        if (wake_ge_idle) begin
          if (motion) begin
            wake_count_next              = '0;
            power_on_next                = 1'b1;
            fan_mode_next                = FAN_HIGH;
            wheel_nibble_next            = WHEEL_LIT;
            purifier_port_next           = 1'b1;
            light_port_next              = 1'b1;
            indicator_bits_next.panel    = 1'b1;
            indicator_bits_next.light    = 1'b1;
            indicator_bits_next.purifier = 1'b1;
          end
        end else begin
          wake_count_next = wake_count + COUNT_WIDTH'(1);
        end
      end

      // wheel chase
      if (power_on_next) begin
        if (fan_mode_next == FAN_OFF) begin
          wheel_nibble_next = WHEEL_DARK;
        end else begin
          unique case (fan_mode_next)
            FAN_LOW: period = chase_period_low;
            FAN_MID: period = chase_period_mid;
            default: period = chase_period_high;
          endcase
          chase_delay_next = chase_delay + PERIOD_W'(1);
          if (chase_delay_next > period) begin
            chase_delay_next   = '0;
            wheel_nibble_next  = chase_pattern;
            chase_pattern_next = {chase_pattern[NIBBLE_W-2:0], 1'b0};
            step_inc           = {1'b0, chase_step} + (STEP_W+1)'(1);
            if (step_inc >= (STEP_W+1)'(CHASE_STEPS)) begin
              chase_step_next    = '0;
              chase_pattern_next = PATTERN_FIRST;
            end else begin
              chase_step_next = step_inc[STEP_W-1:0];
            end
          end
        end
      end

      // forced shutdown while off
      if (!power_on_next) begin
        fan_mode_next       = FAN_OFF;
        smart_mode_next     = 1'b0;
        timer_mode_next     = 1'b0;
        indicator_bits_next = '0;
        wheel_nibble_next   = WHEEL_DARK;
        purifier_port_next  = 1'b0;
        light_port_next     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid   <= 1'b0;
      power_on       <= 1'b0;
      fan_mode       <= FAN_OFF;
      smart_mode     <= 1'b0;
      timer_mode     <= 1'b0;
      wake_enable    <= 1'b0;
      light_port     <= 1'b0;
      purifier_port  <= 1'b0;
      idle_count     <= '0;
      wake_count     <= '0;
      chase_delay    <= '0;
      chase_step     <= '0;
      chase_pattern  <= PATTERN_FIRST;
      wheel_nibble   <= WHEEL_DARK;
      indicator_bits <= '0;
      beep           <= 1'b0;
    end else begin
      if (accept) begin
        result_valid   <= 1'b1;
        power_on       <= power_on_next;
        fan_mode       <= fan_mode_next;
        smart_mode     <= smart_mode_next;
        timer_mode     <= timer_mode_next;
        wake_enable    <= wake_enable_next;
        light_port     <= light_port_next;
        purifier_port  <= purifier_port_next;
        idle_count     <= idle_count_next;
        wake_count     <= wake_count_next;
        chase_delay    <= chase_delay_next;
        chase_step     <= chase_step_next;
        chase_pattern  <= chase_pattern_next;
        wheel_nibble   <= wheel_nibble_next;
        indicator_bits <= indicator_bits_next;
        beep           <= beep_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // mode registers drive the result fields directly
  assign fan_speed      = fan_mode;
  assign power_state    = power_on;
  assign light_drive    = light_port;
  assign purifier_drive = purifier_port;
  assign wheel_leds     = wheel_nibble;
  assign panel_leds     = indicator_bits.panel;
  assign light_led      = indicator_bits.light;
  assign purifier_led   = indicator_bits.purifier;
  assign smart_led      = indicator_bits.smart;
  assign timer_led      = indicator_bits.timer;

  // unit off means every drive is off and the wheel is dark
  a_off_outputs_dark: assert property (@(posedge clk) disable iff (rst)
    !power_on |-> (fan_mode == FAN_OFF) && !light_port && !purifier_port
                  && (wheel_nibble == WHEEL_DARK))
    else $error("outputs active while unit is off");

  // the power key always flips power
  a_power_key_toggles: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_KEY) && (key_code == KEY_POWER)
      |=> power_on != $past(power_on))
    else $error("power key did not toggle power");

  // ticks never beep
  a_tick_no_beep: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_TICK) |=> !beep)
    else $error("beep raised by a tick");

  // chase step stays inside the step count
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (STEP_W+1)'(chase_step) < (STEP_W+1)'(CHASE_STEPS))
    else $error("chase step out of range");

  // keys leave the idle and wake counters alone
  a_key_keeps_counters: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_KEY)
      |=> (idle_count == $past(idle_count)) && (wake_count == $past(wake_count)))
    else $error("key transfer changed a tick counter");

endmodule
